FILE: rtl/core/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and types of the byte run-length compressor.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LANES    = 8;
  localparam int unsigned WORD_W   = BYTE_W * LANES;
  localparam int unsigned CNT_W    = 4;

  // Longest run and longest literal segment.
  localparam logic [BYTE_W-1:0] MAX_RUN = 8'd255;
  localparam logic [BYTE_W-1:0] MAX_SEG = 8'd255;
  localparam int unsigned       LIT_DEPTH = 255;

  // Request from the sequencer to the packer: push one byte, or mark the
  // end of the current item's output.
  typedef struct packed {
    logic              push;
    logic              endm;
    logic [BYTE_W-1:0] data;
  } pk_req_t;

endpackage

FILE: rtl/core/brle_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_packer
// Gathers output bytes into 64-bit words and holds the finished word in an
// output register.
// ----------------------------------------------------------------------------
module brle_packer
  import brle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  pk_req_t           req,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] packed_bytes,
  output logic [CNT_W-1:0]  byte_count,
  output logic              last_of_run
);

  logic [WORD_W-1:0] acc;
  logic [CNT_W-1:0]  acc_cnt;
  logic              out_free;
  logic              need_move;
  logic              fire;

  assign out_free  = !out_valid || !out_stall;
  // A full word is only sent once it is known whether it closes the item.
  assign need_move = (req.push && acc_cnt == CNT_W'(LANES)) ||
                     (req.endm && acc_cnt != '0);
  assign ready     = !need_move || out_free;
  assign fire      = (req.push || req.endm) && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc_cnt   <= '0;
    end else begin
      if (fire && need_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (req.endm) begin
          acc_cnt <= '0;
        end else if (acc_cnt == CNT_W'(LANES) || acc_cnt == '0) begin
          acc_cnt <= CNT_W'(1);
        end else begin
          acc_cnt <= acc_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && need_move) begin
      packed_bytes <= acc;
      byte_count   <= acc_cnt;
      last_of_run  <= req.endm;
    end
    if (fire && req.push) begin
      if (acc_cnt == CNT_W'(LANES) || acc_cnt == '0) begin
        acc <= {{(WORD_W-BYTE_W){1'b0}}, req.data};
      end else begin
        acc[{acc_cnt[2:0], 3'b000} +: BYTE_W] <= req.data;
      end
    end
  end

endmodule

FILE: rtl/core/brle_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_seq
// Group tracking, literal store and the byte sequencer that walks through
// the closing of groups, segment flushes and the terminator.
// ----------------------------------------------------------------------------
module brle_seq
  import brle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              add_terminator,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output pk_req_t           req,
  input  logic              ready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLOSE = 4'd1;
  localparam logic [3:0] S_CDONE = 4'd2;
  localparam logic [3:0] S_LHDR0 = 4'd3;
  localparam logic [3:0] S_LHDR1 = 4'd4;
  localparam logic [3:0] S_LRD   = 4'd5;
  localparam logic [3:0] S_LDAT  = 4'd6;
  localparam logic [3:0] S_RUN0  = 4'd7;
  localparam logic [3:0] S_RUN1  = 4'd8;
  localparam logic [3:0] S_TERM0 = 4'd9;
  localparam logic [3:0] S_TERM1 = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;

  logic [3:0]        state, state_next;
  logic [3:0]        ret, ret_next;
  logic              phase, phase_next;
  logic [BYTE_W-1:0] held_value, held_value_next;
  logic [BYTE_W-1:0] held_count, held_count_next;
  logic [BYTE_W-1:0] lit_cnt, lit_cnt_next;
  logic [BYTE_W-1:0] rd_idx, rd_idx_next;
  logic [BYTE_W-1:0] cur_byte, cur_byte_next;
  logic              cur_last, cur_last_next;

  logic [BYTE_W-1:0] lit_mem [0:LIT_DEPTH-1];
  logic              mem_we;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[lit_cnt] <= held_value;
    end
    if (mem_re) begin
      mem_rdata <= lit_mem[mem_raddr];
    end
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    phase_next      = phase;
    held_value_next = held_value;
    held_count_next = held_count;
    lit_cnt_next    = lit_cnt;
    rd_idx_next     = rd_idx;
    cur_byte_next   = cur_byte;
    cur_last_next   = cur_last;
    req             = '0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = rd_idx;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur_byte_next = data_byte;
          cur_last_next = last_byte;
          phase_next    = 1'b1;
          if (held_count != '0 && data_byte == held_value && held_count < MAX_RUN) begin
            held_count_next = held_count + 8'd1;
            state_next      = last_byte ? S_CLOSE : S_END;
          end else if (held_count == '0) begin
            held_value_next = data_byte;
            held_count_next = 8'd1;
            state_next      = last_byte ? S_CLOSE : S_END;
          end else begin
            phase_next = 1'b0;
            state_next = S_CLOSE;
          end
        end
      end

      S_CLOSE: begin
        if (held_count == '0) begin
          state_next = S_CDONE;
        end else if (held_count == 8'd1) begin
          // A single byte joins the literal segment.
          mem_we          = 1'b1;
          lit_cnt_next    = lit_cnt + 8'd1;
          held_count_next = '0;
          if (lit_cnt == MAX_SEG - 8'd1) begin
            ret_next   = S_CDONE;
            state_next = S_LHDR0;
          end else begin
            state_next = S_CDONE;
          end
        end else if (lit_cnt != '0) begin
          ret_next   = S_RUN0;
          state_next = S_LHDR0;
        end else begin
          state_next = S_RUN0;
        end
      end

      S_CDONE: begin
        if (!phase) begin
          held_value_next = cur_byte;
          held_count_next = 8'd1;
          phase_next      = 1'b1;
          state_next      = cur_last ? S_CLOSE : S_END;
        end else if (lit_cnt != '0) begin
          ret_next   = S_TERM0;
          state_next = S_LHDR0;
        end else begin
          state_next = S_TERM0;
        end
      end

      S_LHDR0: begin
        req.push = 1'b1;
        req.data = '0;
        if (ready) begin
          state_next = S_LHDR1;
        end
      end

      S_LHDR1: begin
        req.push = 1'b1;
        req.data = lit_cnt;
        if (ready) begin
          state_next = S_LRD;
        end
      end

      S_LRD: begin
        mem_re      = 1'b1;
        mem_raddr   = '0;
        rd_idx_next = '0;
        state_next  = S_LDAT;
      end

      S_LDAT: begin
        // The read of the next entry goes out in the cycle its
        // predecessor is taken, so the segment streams at one byte a cycle while the packer is ready.
        req.push = 1'b1;
        req.data = mem_rdata;
        if (ready) begin
          if (rd_idx + 8'd1 == lit_cnt) begin
            lit_cnt_next = '0;
            state_next   = ret;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = rd_idx + 8'd1;
            rd_idx_next = rd_idx + 8'd1;
          end
        end
      end

      S_RUN0: begin
        req.push = 1'b1;
        req.data = held_count;
        if (ready) begin
          state_next = S_RUN1;
        end
      end

      S_RUN1: begin
        req.push = 1'b1;
        req.data = held_value;
        if (ready) begin
          held_count_next = '0;
          state_next      = S_CDONE;
        end
      end

      S_TERM0: begin
        held_value_next = '0;
        if (add_terminator) begin
          req.push = 1'b1;
          req.data = '0;
          if (ready) begin
            state_next = S_TERM1;
          end
        end else begin
          state_next = S_END;
        end
      end

      S_TERM1: begin
        req.push = 1'b1;
        req.data = '0;
        if (ready) begin
          state_next = S_END;
        end
      end

      S_END: begin
        req.endm = 1'b1;
        if (ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      phase      <= 1'b0;
      held_value <= '0;
      held_count <= '0;
      lit_cnt    <= '0;
      rd_idx     <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      phase      <= phase_next;
      held_value <= held_value_next;
      held_count <= held_count_next;
      lit_cnt    <= lit_cnt_next;
      rd_idx     <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    cur_last <= cur_last_next;
  end

endmodule

FILE: rtl/core/byte_rle_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_rle_compressor
// Run-length compressor for a byte stream with literal segments, packing
// the produced bytes eight to a 64-bit output beat.
// ----------------------------------------------------------------------------
// One input byte is handled at a time. A byte that extends the current run
// passes the idle and end states; one that closes a group passes the idle,
// close, close-done and end states, plus both run states for an emitted run
// pair, plus the literal header states, a read state and one data step per
// stored byte when a segment is flushed from the 255-entry literal memory.
// The last byte also closes its group and passes the terminator states,
// which push zero bytes if enabled. The sequencer pushes at most one byte
// per cycle into the packer, and a stalled output beat holds the sequencer.
// Configuration (add_terminator at address 0) may be written only while no
// byte is in progress.
module byte_rle_compressor
  import brle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] packed_bytes,
  output logic [CNT_W-1:0]  byte_count,
  output logic              last_of_run
);

  logic    add_terminator;
  pk_req_t req;
  logic    ready;
  logic    unused_addr;

  // Only one register exists, so every address decodes to it.
  assign unused_addr = ^paddr;
  assign pready      = 1'b1;
  assign prdata      = {31'b0, add_terminator & (unused_addr | ~unused_addr)};

  always_ff @(posedge clk) begin
    if (rst) begin
      add_terminator <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      add_terminator <= pwdata[0];
    end
  end

  brle_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .add_terminator (add_terminator),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .req            (req),
    .ready          (ready)
  );

  brle_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .ready        (ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: rtl/core/brle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_checker
// Port-level checks of the compressor output, bound to the top level.
// ----------------------------------------------------------------------------
module brle_checker
  import brle_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] packed_bytes,
  input logic [CNT_W-1:0]  byte_count,
  input logic              last_of_run
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != '0 && byte_count <= CNT_W'(LANES)))
    else $error("byte_count out of range");

  // Only the closing beat of an item may be partly filled.
  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> byte_count == CNT_W'(LANES))
    else $error("partial beat without last_of_run");

  a_single_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == CNT_W'(1) |-> packed_bytes[WORD_W-1:BYTE_W] == '0)
    else $error("unused byte lanes not zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_bytes) &&
      $stable(byte_count) && $stable(last_of_run))
    else $error("stalled beat changed");

endmodule

bind byte_rle_compressor brle_checker u_brle_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .packed_bytes (packed_bytes),
  .byte_count   (byte_count),
  .last_of_run  (last_of_run)
);
